FILE: hw/rtl/gsp_pkg.sv
package gsp_pkg;

   localparam int VTX_W = 10;

   typedef enum logic [5:0] {
      ST_CLR,
      ST_IDLE,
      ST_LD_RDA,
      ST_LD_WRA,
      ST_LD_RDB,
      ST_LD_WRB,
      ST_PFX_RD,
      ST_PFX_WR,
      ST_PFX_END,
      ST_FILL_RD,
      ST_FILL_LO,
      ST_FILL_WLO,
      ST_FILL_WHI,
      ST_BCLR,
      ST_ENQ_RD,
      ST_ENQ_CHK,
      ST_Q_RDT,
      ST_Q_WR1,
      ST_Q_WR2,
      ST_BFIN,
      ST_BCUR,
      ST_TOP,
      ST_S_CHK,
      ST_S_EDGE,
      ST_S_NB,
      ST_S_GONE,
      ST_C_CHK,
      ST_C_HEAD,
      ST_C_POP,
      ST_C_TEST,
      ST_C_ST1,
      ST_C_ST2,
      ST_EMIT
   } state_type;

   typedef enum logic [5:0] {
      CMD_NOP,
      CMD_CLR,
      CMD_LD_ACCEPT,
      CMD_RD_DEG_LO,
      CMD_INC_DEG_LO,
      CMD_RD_DEG_HI,
      CMD_INC_DEG_HI,
      CMD_BLD_INIT,
      CMD_PFX_RD,
      CMD_PFX_WR,
      CMD_PFX_END,
      CMD_FILL_RD,
      CMD_FILL_LO,
      CMD_FILL_WLO,
      CMD_FILL_WHI,
      CMD_BCLR,
      CMD_ENQ_RD,
      CMD_ENQ_CHK,
      CMD_Q_RDT,
      CMD_Q_WR1,
      CMD_Q_WR2,
      CMD_BFIN,
      CMD_CUR_LOAD,
      CMD_EMIT_DONE,
      CMD_S_RDADJ,
      CMD_S_EDGE,
      CMD_S_NB,
      CMD_S_HIT,
      CMD_C_RDPOOL,
      CMD_C_HEAD_RD,
      CMD_C_POP,
      CMD_C_TAKE,
      CMD_C_ST1,
      CMD_C_ST2,
      CMD_EMIT
   } cmd_type;

   typedef enum logic [1:0] {
      PH_LOAD,
      PH_PEEL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic ld_ok;
      logic rsp_busy;
      logic last_v;
      logic last_n;
      logic last_b;
      logic n_zero;
      logic enq_last;
      logic deg_zero;
      logic enq_skip;
      logic tail_valid;
      logic dmax_zero;
      logic apos_lt;
      logic gone_hit;
      logic cur_valid;
      logic level_le1;
      logic pid_live;
   } status_type;

endpackage

FILE: hw/rtl/gsp_req_if.sv
interface gsp_req_if
   import gsp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [VTX_W-1:0] vertex_a;
   logic [VTX_W-1:0] vertex_b;

   modport source (output valid, req_type, vertex_a, vertex_b, input ready);
   modport sink (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

FILE: hw/rtl/gsp_rsp_if.sv
interface gsp_rsp_if
   import gsp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [VTX_W-1:0] star_center;
   logic [VTX_W-1:0] edge_low;
   logic [VTX_W-1:0] edge_high;
   logic             first_of_star;
   logic             done_res;
   logic             error;

   modport source (output valid, star_center, edge_low, edge_high, first_of_star,
                   done_res, error, input ready);
   modport sink (input valid, star_center, edge_low, edge_high, first_of_star,
                 done_res, error, output ready);
endinterface

FILE: hw/rtl/graph_star_peeling.sv
// Greedy star decomposition by degree-bucket peeling. Load requests (req_type 0)
// store one edge each; a self-loop, a vertex out of range or a full edge store
// sets the sticky error flag. The first fetch request (req_type 1) builds the
// adjacency lists and degree buckets from memory. Every fetch then returns one
// record, an edge or the done marker; to find an edge it walks bucket entries
// (skipping stale ones, taking a live one as a centre, passing empty bucket
// levels) and adjacency entries (skipping neighbors already removed).
// One request is worked at a time. After reset a clearing pass over all
// MAX_VERTICES entries zeroes degrees and removed marks before the first
// request is taken.
module graph_star_peeling
   import gsp_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
)(
   input logic       clock,
   input logic       reset,
   gsp_req_if.sink   req_chan,
   gsp_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type stat;

   gsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_chan.ready)
   );

   gsp_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .vertex_a      (req_chan.vertex_a),
      .vertex_b      (req_chan.vertex_b),
      .rsp_ready     (rsp_chan.ready),
      .stat          (stat),
      .rsp_valid     (rsp_chan.valid),
      .star_center   (rsp_chan.star_center),
      .edge_low      (rsp_chan.edge_low),
      .edge_high     (rsp_chan.edge_high),
      .first_of_star (rsp_chan.first_of_star),
      .done_res      (rsp_chan.done_res),
      .error         (rsp_chan.error)
   );

endmodule

FILE: hw/rtl/gsp_ctrl.sv
module gsp_ctrl
   import gsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   input  status_type stat,
   output cmd_type    cmd,
   output logic       req_ready
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      in_star_ff, in_star_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && !stat.rsp_busy;
   assign accept    = req_ready && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         phase_ff   <= PH_LOAD;
         in_star_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         in_star_ff <= in_star_in;
      end
   end

   // where to go once an enqueue finishes
   function automatic state_type enq_return(input phase_type ph, input logic last);
      if (ph == PH_LOAD) begin
         return last ? ST_BFIN : ST_ENQ_RD;
      end
      return ST_EMIT;
   endfunction

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      in_star_in = in_star_ff;
      case (state_ff)
         ST_CLR:      if (stat.last_v) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (!req_type) begin
                  if (phase_ff == PH_LOAD && stat.ld_ok) state_in = ST_LD_RDA;
               end else if (phase_ff == PH_LOAD) begin
                  state_in = ST_PFX_RD;
               end else begin
                  state_in = ST_TOP;
               end
            end
         end
         ST_LD_RDA:   state_in = ST_LD_WRA;
         ST_LD_WRA:   state_in = ST_LD_RDB;
         ST_LD_RDB:   state_in = ST_LD_WRB;
         ST_LD_WRB:   state_in = ST_IDLE;
         ST_PFX_RD:   state_in = ST_PFX_WR;
         ST_PFX_WR:   state_in = stat.last_v ? ST_PFX_END : ST_PFX_RD;
         ST_PFX_END:  state_in = stat.n_zero ? ST_BCLR : ST_FILL_RD;
         ST_FILL_RD:  state_in = ST_FILL_LO;
         ST_FILL_LO:  state_in = ST_FILL_WLO;
         ST_FILL_WLO: state_in = ST_FILL_WHI;
         ST_FILL_WHI: state_in = stat.last_n ? ST_BCLR : ST_FILL_RD;
         ST_BCLR:     if (stat.last_b) state_in = ST_ENQ_RD;
         ST_ENQ_RD:   state_in = ST_ENQ_CHK;
         ST_ENQ_CHK: begin
            if (stat.deg_zero) state_in = stat.last_v ? ST_BFIN : ST_ENQ_RD;
            else state_in = ST_Q_RDT;
         end
         ST_Q_RDT: begin
            if (stat.enq_skip) state_in = enq_return(phase_ff, stat.enq_last);
            else state_in = ST_Q_WR1;
         end
         ST_Q_WR1: begin
            if (stat.tail_valid) state_in = ST_Q_WR2;
            else state_in = enq_return(phase_ff, stat.enq_last);
         end
         ST_Q_WR2:    state_in = enq_return(phase_ff, stat.enq_last);
         ST_BFIN: begin
            in_star_in = 1'b0;
            if (stat.dmax_zero) begin
               phase_in = PH_DONE;
               state_in = ST_TOP;
            end else begin
               phase_in = PH_PEEL;
               state_in = ST_BCUR;
            end
         end
         ST_BCUR:     state_in = ST_TOP;
         ST_TOP: begin
            if (phase_ff == PH_DONE) state_in = ST_IDLE;
            else if (in_star_ff) state_in = ST_S_CHK;
            else state_in = ST_C_CHK;
         end
         ST_S_CHK: begin
            if (stat.apos_lt) begin
               state_in = ST_S_EDGE;
            end else begin
               in_star_in = 1'b0;
               state_in   = ST_C_CHK;
            end
         end
         ST_S_EDGE:   state_in = ST_S_NB;
         ST_S_NB:     state_in = ST_S_GONE;
         ST_S_GONE:   state_in = stat.gone_hit ? ST_S_CHK : ST_Q_RDT;
         ST_C_CHK: begin
            if (stat.cur_valid) begin
               state_in = ST_C_POP;
            end else if (stat.level_le1) begin
               phase_in = PH_DONE;
               state_in = ST_TOP;
            end else begin
               state_in = ST_C_HEAD;
            end
         end
         ST_C_HEAD:   state_in = ST_C_CHK;
         ST_C_POP:    state_in = ST_C_TEST;
         ST_C_TEST: begin
            if (stat.pid_live) begin
               in_star_in = 1'b1;
               state_in   = ST_C_ST1;
            end else begin
               state_in = ST_C_CHK;
            end
         end
         ST_C_ST1:    state_in = ST_C_ST2;
         ST_C_ST2:    state_in = ST_S_CHK;
         ST_EMIT:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = CMD_NOP;
      case (state_ff)
         ST_CLR: cmd = CMD_CLR;
         ST_IDLE: begin
            if (accept) begin
               if (!req_type && phase_ff == PH_LOAD) cmd = CMD_LD_ACCEPT;
               else if (req_type && phase_ff == PH_LOAD) cmd = CMD_BLD_INIT;
            end
         end
         ST_LD_RDA:   cmd = CMD_RD_DEG_LO;
         ST_LD_WRA:   cmd = CMD_INC_DEG_LO;
         ST_LD_RDB:   cmd = CMD_RD_DEG_HI;
         ST_LD_WRB:   cmd = CMD_INC_DEG_HI;
         ST_PFX_RD:   cmd = CMD_PFX_RD;
         ST_PFX_WR:   cmd = CMD_PFX_WR;
         ST_PFX_END:  cmd = CMD_PFX_END;
         ST_FILL_RD:  cmd = CMD_FILL_RD;
         ST_FILL_LO:  cmd = CMD_FILL_LO;
         ST_FILL_WLO: cmd = CMD_FILL_WLO;
         ST_FILL_WHI: cmd = CMD_FILL_WHI;
         ST_BCLR:     cmd = CMD_BCLR;
         ST_ENQ_RD:   cmd = CMD_ENQ_RD;
         ST_ENQ_CHK:  cmd = CMD_ENQ_CHK;
         ST_Q_RDT:    cmd = CMD_Q_RDT;
         ST_Q_WR1:    cmd = CMD_Q_WR1;
         ST_Q_WR2:    cmd = CMD_Q_WR2;
         ST_BFIN:     cmd = stat.dmax_zero ? CMD_NOP : CMD_BFIN;
         ST_BCUR:     cmd = CMD_CUR_LOAD;
         ST_TOP:      cmd = (phase_ff == PH_DONE) ? CMD_EMIT_DONE : CMD_NOP;
         ST_S_CHK:    cmd = stat.apos_lt ? CMD_S_RDADJ : CMD_NOP;
         ST_S_EDGE:   cmd = CMD_S_EDGE;
         ST_S_NB:     cmd = CMD_S_NB;
         ST_S_GONE:   cmd = stat.gone_hit ? CMD_NOP : CMD_S_HIT;
         ST_C_CHK: begin
            if (stat.cur_valid) cmd = CMD_C_RDPOOL;
            else if (!stat.level_le1) cmd = CMD_C_HEAD_RD;
         end
         ST_C_HEAD:   cmd = CMD_CUR_LOAD;
         ST_C_POP:    cmd = CMD_C_POP;
         ST_C_TEST:   cmd = stat.pid_live ? CMD_C_TAKE : CMD_NOP;
         ST_C_ST1:    cmd = CMD_C_ST1;
         ST_C_ST2:    cmd = CMD_C_ST2;
         ST_EMIT:     cmd = CMD_EMIT;
         default:     cmd = CMD_NOP;
      endcase
   end

endmodule

FILE: hw/rtl/gsp_datapath.sv
module gsp_datapath
   import gsp_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
)(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [VTX_W-1:0] vertex_a,
   input  logic [VTX_W-1:0] vertex_b,
   input  logic             rsp_ready,
   output status_type       stat,
   output logic             rsp_valid,
   output logic [VTX_W-1:0] star_center,
   output logic [VTX_W-1:0] edge_low,
   output logic [VTX_W-1:0] edge_high,
   output logic             first_of_star,
   output logic             done_res,
   output logic             error
);

   localparam int MV      = MAX_VERTICES;
   localparam int ME      = MAX_EDGES;
   localparam int PS      = MV + 2 * ME;
   localparam int VAW     = $clog2(MV);
   localparam int EAW     = (ME > 1) ? $clog2(ME) : 1;
   localparam int NW      = $clog2(ME + 1);
   localparam int DW      = $clog2(ME + 1);
   localparam int SW      = $clog2(2 * ME + 1);
   localparam int SAW     = $clog2(MV + 1);
   localparam int AAW     = $clog2(2 * ME);
   localparam int PAW     = $clog2(PS);
   localparam int PCW     = $clog2(PS + 1);
   localparam int CNT_MAX = (MV > ME + 1) ? MV : ME + 1;
   localparam int CW      = $clog2(CNT_MAX);

   // memories
   logic [2*VTX_W-1:0] edge_mem  [ME];
   logic [DW-1:0]      deg_mem   [MV];
   logic               gone_mem  [MV];
   logic [SW-1:0]      start_mem [MV+1];
   logic [SW-1:0]      fill_mem  [MV];
   logic [EAW-1:0]     adj_mem   [2*ME];
   logic [PAW:0]       head_mem  [ME+1];
   logic [PAW:0]       tail_mem  [ME+1];
   logic [VAW-1:0]     pvtx_mem  [PS];
   logic [PAW:0]       pnxt_mem  [PS];

   logic [2*VTX_W-1:0] edge_q_ff;
   logic [DW-1:0]      deg_q_ff;
   logic               gone_q_ff;
   logic [SW-1:0]      start_q_ff;
   logic [SW-1:0]      fill_q_ff;
   logic [EAW-1:0]     adj_q_ff;
   logic [PAW:0]       head_q_ff;
   logic [PAW:0]       tail_q_ff;
   logic [VAW-1:0]     pvtx_q_ff;
   logic [PAW:0]       pnxt_q_ff;

   logic               edge_we, edge_re;
   logic [EAW-1:0]     edge_wa, edge_ra;
   logic [2*VTX_W-1:0] edge_wd;
   logic               deg_we, deg_re;
   logic [VAW-1:0]     deg_wa, deg_ra;
   logic [DW-1:0]      deg_wd;
   logic               gone_we, gone_re, gone_wd;
   logic [VAW-1:0]     gone_wa, gone_ra;
   logic               start_we, start_re;
   logic [SAW-1:0]     start_wa, start_ra;
   logic [SW-1:0]      start_wd;
   logic               fill_we, fill_re;
   logic [VAW-1:0]     fill_wa, fill_ra;
   logic [SW-1:0]      fill_wd;
   logic               adj_we, adj_re;
   logic [AAW-1:0]     adj_wa, adj_ra;
   logic [EAW-1:0]     adj_wd;
   logic               head_we, head_re, tail_we, tail_re;
   logic [DW-1:0]      head_wa, head_ra, tail_wa, tail_ra;
   logic [PAW:0]       head_wd, tail_wd;
   logic               pvtx_we, pnxt_we, pool_re;
   logic [PAW-1:0]     pvtx_wa, pnxt_wa, pool_ra;
   logic [VAW-1:0]     pvtx_wd;
   logic [PAW:0]       pnxt_wd;

   // registers
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [SW-1:0]    acc_ff, acc_in;
   logic [DW-1:0]    dmax_ff, dmax_in;
   logic [NW-1:0]    n_ff, n_in;
   logic             err_ff, err_in;
   logic [PCW-1:0]   pu_ff, pu_in;
   logic [VTX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [DW-1:0]    level_ff, level_in;
   logic [PAW:0]     cur_ff, cur_in;
   logic [VAW-1:0]   centre_ff, centre_in;
   logic [SW-1:0]    apos_ff, apos_in, aend_ff, aend_in;
   logic             first_ff, first_in;
   logic [VAW-1:0]   nb_ff, nb_in;
   logic [DW-1:0]    d_ff, d_in;
   logic [VAW-1:0]   v_ff, v_in;
   logic             enq_last_ff, enq_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0] center_ff, center_in, elo_ff, elo_in, ehi_ff, ehi_in;
   logic             rfirst_ff, rfirst_in, rdone_ff, rdone_in, rerr_ff, rerr_in;

   logic [VTX_W-1:0] ord_lo, ord_hi, eq_lo, eq_hi, nb_sel;
   logic             ld_ok;

   assign ord_lo = (vertex_a > vertex_b) ? vertex_b : vertex_a;
   assign ord_hi = (vertex_a > vertex_b) ? vertex_a : vertex_b;
   assign ld_ok  = (ord_lo != ord_hi) && (32'(ord_hi) < 32'(MV)) && (32'(n_ff) < 32'(ME));
   assign eq_lo  = edge_q_ff[VTX_W-1:0];
   assign eq_hi  = edge_q_ff[2*VTX_W-1:VTX_W];
   assign nb_sel = (VAW'(eq_lo) == centre_ff) ? eq_hi : eq_lo;

   always_comb begin
      stat.ld_ok      = ld_ok;
      stat.rsp_busy   = rsp_valid_ff;
      stat.last_v     = (32'(cnt_ff) == 32'(MV - 1));
      stat.last_n     = (32'(cnt_ff) + 32'd1 == 32'(n_ff));
      stat.last_b     = (32'(cnt_ff) == 32'(ME));
      stat.n_zero     = (n_ff == '0);
      stat.enq_last   = enq_last_ff;
      stat.deg_zero   = (deg_q_ff == '0);
      stat.enq_skip   = (d_ff == '0) || (32'(d_ff) > 32'(ME)) || (32'(pu_ff) >= 32'(PS));
      stat.tail_valid = tail_q_ff[PAW];
      stat.dmax_zero  = (dmax_ff == '0);
      stat.apos_lt    = (apos_ff < aend_ff) && (32'(apos_ff) < 32'(2 * ME));
      stat.gone_hit   = gone_q_ff;
      stat.cur_valid  = cur_ff[PAW];
      stat.level_le1  = (level_ff <= DW'(1));
      stat.pid_live   = !gone_q_ff && (deg_q_ff == level_ff);
   end

   always_comb begin
      edge_we = 1'b0; edge_re = 1'b0; edge_wa = EAW'(n_ff); edge_ra = EAW'(cnt_ff);
      edge_wd = {ord_hi, ord_lo};
      deg_we = 1'b0; deg_re = 1'b0; deg_wa = VAW'(cnt_ff); deg_ra = VAW'(cnt_ff);
      deg_wd = '0;
      gone_we = 1'b0; gone_re = 1'b0; gone_wa = VAW'(cnt_ff); gone_ra = nb_ff;
      gone_wd = 1'b0;
      start_we = 1'b0; start_re = 1'b0; start_wa = SAW'(cnt_ff); start_ra = SAW'(v_ff);
      start_wd = acc_ff;
      fill_we = 1'b0; fill_re = 1'b0; fill_wa = VAW'(cnt_ff); fill_ra = VAW'(hi_ff);
      fill_wd = acc_ff;
      adj_we = 1'b0; adj_re = 1'b0; adj_wa = AAW'(fill_q_ff); adj_ra = AAW'(apos_ff);
      adj_wd = EAW'(cnt_ff);
      head_we = 1'b0; head_re = 1'b0; head_wa = d_ff; head_ra = dmax_ff; head_wd = '0;
      tail_we = 1'b0; tail_re = 1'b0; tail_wa = d_ff; tail_ra = d_ff; tail_wd = '0;
      pvtx_we = 1'b0; pnxt_we = 1'b0; pool_re = 1'b0;
      pvtx_wa = PAW'(pu_ff); pnxt_wa = PAW'(pu_ff); pool_ra = cur_ff[PAW-1:0];
      pvtx_wd = v_ff; pnxt_wd = '0;

      cnt_in = cnt_ff; acc_in = acc_ff; dmax_in = dmax_ff; n_in = n_ff; err_in = err_ff;
      pu_in = pu_ff; lo_in = lo_ff; hi_in = hi_ff; level_in = level_ff; cur_in = cur_ff;
      centre_in = centre_ff; apos_in = apos_ff; aend_in = aend_ff; first_in = first_ff;
      nb_in = nb_ff; d_in = d_ff; v_in = v_ff; enq_last_in = enq_last_ff;
      center_in = center_ff; elo_in = elo_ff; ehi_in = ehi_ff; rfirst_in = rfirst_ff;
      rdone_in = rdone_ff; rerr_in = rerr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (cmd)
         CMD_CLR: begin
            deg_we  = 1'b1;
            gone_we = 1'b1;
            cnt_in  = stat.last_v ? '0 : cnt_ff + CW'(1);
         end
         CMD_LD_ACCEPT: begin
            lo_in = ord_lo;
            hi_in = ord_hi;
            if (ld_ok) begin
               edge_we = 1'b1;
               n_in    = n_ff + NW'(1);
            end else begin
               err_in = 1'b1;
            end
         end
         CMD_RD_DEG_LO: begin
            deg_re = 1'b1;
            deg_ra = VAW'(lo_ff);
         end
         CMD_INC_DEG_LO: begin
            deg_we = 1'b1;
            deg_wa = VAW'(lo_ff);
            deg_wd = deg_q_ff + DW'(1);
         end
         CMD_RD_DEG_HI: begin
            deg_re = 1'b1;
            deg_ra = VAW'(hi_ff);
         end
         CMD_INC_DEG_HI: begin
            deg_we = 1'b1;
            deg_wa = VAW'(hi_ff);
            deg_wd = deg_q_ff + DW'(1);
         end
         CMD_BLD_INIT: begin
            cnt_in  = '0;
            acc_in  = '0;
            dmax_in = '0;
            pu_in   = '0;
         end
         CMD_PFX_RD: deg_re = 1'b1;
         CMD_PFX_WR: begin
            start_we = 1'b1;
            fill_we  = 1'b1;
            acc_in   = acc_ff + SW'(deg_q_ff);
            if (deg_q_ff > dmax_ff) dmax_in = deg_q_ff;
            cnt_in   = stat.last_v ? '0 : cnt_ff + CW'(1);
         end
         CMD_PFX_END: begin
            // end offset of the last vertex
            start_we = 1'b1;
            start_wa = SAW'(MV);
         end
         CMD_FILL_RD: edge_re = 1'b1;
         CMD_FILL_LO: begin
            lo_in   = eq_lo;
            hi_in   = eq_hi;
            fill_re = 1'b1;
            fill_ra = VAW'(eq_lo);
         end
         CMD_FILL_WLO: begin
            adj_we  = 1'b1;
            fill_we = 1'b1;
            fill_wa = VAW'(lo_ff);
            fill_wd = fill_q_ff + SW'(1);
            fill_re = 1'b1;
         end
         CMD_FILL_WHI: begin
            adj_we  = 1'b1;
            fill_we = 1'b1;
            fill_wa = VAW'(hi_ff);
            fill_wd = fill_q_ff + SW'(1);
            cnt_in  = stat.last_n ? '0 : cnt_ff + CW'(1);
         end
         CMD_BCLR: begin
            head_we = 1'b1;
            head_wa = DW'(cnt_ff);
            tail_we = 1'b1;
            tail_wa = DW'(cnt_ff);
            cnt_in  = stat.last_b ? '0 : cnt_ff + CW'(1);
         end
         CMD_ENQ_RD: deg_re = 1'b1;
         CMD_ENQ_CHK: begin
            d_in        = deg_q_ff;
            v_in        = VAW'(cnt_ff);
            enq_last_in = stat.last_v;
            cnt_in      = cnt_ff + CW'(1);
         end
         CMD_Q_RDT: tail_re = 1'b1;
         CMD_Q_WR1: begin
            pvtx_we = 1'b1;
            pnxt_we = 1'b1;
            tail_we = 1'b1;
            tail_wd = {1'b1, PAW'(pu_ff)};
            if (!tail_q_ff[PAW]) begin
               head_we = 1'b1;
               head_wd = {1'b1, PAW'(pu_ff)};
               pu_in   = pu_ff + PCW'(1);
            end
         end
         CMD_Q_WR2: begin
            pnxt_we = 1'b1;
            pnxt_wa = tail_q_ff[PAW-1:0];
            pnxt_wd = {1'b1, PAW'(pu_ff)};
            pu_in   = pu_ff + PCW'(1);
         end
         CMD_BFIN: begin
            level_in = dmax_ff;
            head_re  = 1'b1;
         end
         CMD_CUR_LOAD: cur_in = head_q_ff;
         CMD_EMIT_DONE: begin
            center_in    = '0;
            elo_in       = '0;
            ehi_in       = '0;
            rfirst_in    = 1'b0;
            rdone_in     = 1'b1;
            rerr_in      = err_ff;
            rsp_valid_in = 1'b1;
         end
         CMD_S_RDADJ: begin
            adj_re  = 1'b1;
            apos_in = apos_ff + SW'(1);
         end
         CMD_S_EDGE: begin
            edge_re = 1'b1;
            edge_ra = adj_q_ff;
         end
         CMD_S_NB: begin
            lo_in   = eq_lo;
            hi_in   = eq_hi;
            nb_in   = VAW'(nb_sel);
            gone_re = 1'b1;
            gone_ra = VAW'(nb_sel);
            deg_re  = 1'b1;
            deg_ra  = VAW'(nb_sel);
         end
         CMD_S_HIT: begin
            d_in      = (deg_q_ff != '0) ? deg_q_ff - DW'(1) : '0;
            deg_we    = 1'b1;
            deg_wa    = nb_ff;
            deg_wd    = (deg_q_ff != '0) ? deg_q_ff - DW'(1) : '0;
            v_in      = nb_ff;
            center_in = VTX_W'(centre_ff);
            elo_in    = lo_ff;
            ehi_in    = hi_ff;
            rfirst_in = first_ff;
            rdone_in  = 1'b0;
            rerr_in   = err_ff;
            first_in  = 1'b0;
         end
         CMD_C_RDPOOL: pool_re = 1'b1;
         CMD_C_HEAD_RD: begin
            level_in = level_ff - DW'(1);
            head_re  = 1'b1;
            head_ra  = level_ff - DW'(1);
         end
         CMD_C_POP: begin
            v_in    = pvtx_q_ff;
            cur_in  = pnxt_q_ff;
            gone_re = 1'b1;
            gone_ra = pvtx_q_ff;
            deg_re  = 1'b1;
            deg_ra  = pvtx_q_ff;
         end
         CMD_C_TAKE: begin
            gone_we   = 1'b1;
            gone_wa   = v_ff;
            gone_wd   = 1'b1;
            centre_in = v_ff;
            first_in  = 1'b1;
            start_re  = 1'b1;
         end
         CMD_C_ST1: begin
            apos_in  = start_q_ff;
            start_re = 1'b1;
            start_ra = SAW'(v_ff) + SAW'(1);
         end
         CMD_C_ST2: aend_in = start_q_ff;
         CMD_EMIT: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_wa] <= edge_wd;
      if (edge_re) edge_q_ff <= edge_mem[edge_ra];
      if (deg_we) deg_mem[deg_wa] <= deg_wd;
      if (deg_re) deg_q_ff <= deg_mem[deg_ra];
      if (gone_we) gone_mem[gone_wa] <= gone_wd;
      if (gone_re) gone_q_ff <= gone_mem[gone_ra];
      if (start_we) start_mem[start_wa] <= start_wd;
      if (start_re) start_q_ff <= start_mem[start_ra];
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      if (fill_re) fill_q_ff <= fill_mem[fill_ra];
      if (adj_we) adj_mem[adj_wa] <= adj_wd;
      if (adj_re) adj_q_ff <= adj_mem[adj_ra];
      if (head_we) head_mem[head_wa] <= head_wd;
      if (head_re) head_q_ff <= head_mem[head_ra];
      if (tail_we) tail_mem[tail_wa] <= tail_wd;
      if (tail_re) tail_q_ff <= tail_mem[tail_ra];
      if (pvtx_we) pvtx_mem[pvtx_wa] <= pvtx_wd;
      if (pnxt_we) pnxt_mem[pnxt_wa] <= pnxt_wd;
      if (pool_re) begin
         pvtx_q_ff <= pvtx_mem[pool_ra];
         pnxt_q_ff <= pnxt_mem[pool_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         n_ff         <= '0;
         err_ff       <= 1'b0;
         pu_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         err_ff       <= err_in;
         pu_ff        <= pu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      dmax_ff     <= dmax_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      level_ff    <= level_in;
      cur_ff      <= cur_in;
      centre_ff   <= centre_in;
      apos_ff     <= apos_in;
      aend_ff     <= aend_in;
      first_ff    <= first_in;
      nb_ff       <= nb_in;
      d_ff        <= d_in;
      v_ff        <= v_in;
      enq_last_ff <= enq_last_in;
      center_ff   <= center_in;
      elo_ff      <= elo_in;
      ehi_ff      <= ehi_in;
      rfirst_ff   <= rfirst_in;
      rdone_ff    <= rdone_in;
      rerr_ff     <= rerr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign star_center   = center_ff;
   assign edge_low      = elo_ff;
   assign edge_high     = ehi_ff;
   assign first_of_star = rfirst_ff;
   assign done_res      = rdone_ff;
   assign error         = rerr_ff;

endmodule
